### src/i486_atomic_op_executor_defines.svh
// Assertion macros used by the executor's execute stage (iaoe_back)
`ifndef I486_ATOMIC_OP_EXECUTOR_DEFINES_SVH
`define I486_ATOMIC_OP_EXECUTOR_DEFINES_SVH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

### src/iaoe_pkg.sv
// Shared types and constants for the atomic op executor
package iaoe_pkg;
  localparam logic [31:0] Endbr32Word = 32'hfb1e0ff3;
  localparam logic [31:0] LimitReset  = 32'hc000_0000;
  localparam logic [7:0]  LockByte    = 8'hf0;
  localparam logic [7:0]  EscByte     = 8'h0f;
  localparam logic [7:0]  CmpxchgOp   = 8'hb1;
  localparam logic [7:0]  XaddOp      = 8'hc1;
  localparam logic [7:0]  BswapLo     = 8'hc8;
  localparam logic [7:0]  BswapHi     = 8'hcf;
  localparam logic [31:0] FlagAddMask = 32'h0000_08d5;
  localparam int unsigned QDepth      = 2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0, CMD_READ = 2'd1, CMD_EXEC = 2'd2, CMD_DATA = 2'd3
  } cmd_e;
  typedef enum logic [1:0] {
    KIND_REG = 2'd0, KIND_REQ = 2'd1, KIND_WR = 2'd2, KIND_DONE = 2'd3
  } kind_e;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_UNSUP = 2'd1, ST_FAULT = 2'd2, ST_SEQ = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  idx;
    logic [31:0] data;
    logic [31:0] lo;
    logic [31:0] hi;
  } txn_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    logic [31:0] value;
    status_e     status;
    logic        last;
  } res_t;

  function automatic logic [7:0] code_byte(logic [31:0] lo, logic [31:0] hi,
                                           logic [2:0] i);
    logic [63:0] w;
    w = {hi, lo};
    return w[{i, 3'b000} +: 8];
  endfunction

  function automatic logic [31:0] code_word(logic [31:0] lo, logic [31:0] hi,
                                            logic [2:0] p);
    return {code_byte(lo, hi, p + 3'd3), code_byte(lo, hi, p + 3'd2),
            code_byte(lo, hi, p + 3'd1), code_byte(lo, hi, p)};
  endfunction

  function automatic logic [31:0] add_flags(logic [31:0] a, logic [31:0] b,
                                            logic [31:0] fin);
    logic [32:0] s;
    logic [31:0] r;
    logic [31:0] f;
    s = {1'b0, a} + {1'b0, b};
    r = s[31:0];
    f = fin & ~FlagAddMask;
    f[0]  = s[32];
    f[2]  = ~(^r[7:0]);
    f[4]  = a[4] ^ b[4] ^ r[4];
    f[6]  = (r == 32'd0);
    f[7]  = r[31];
    f[11] = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
    return f;
  endfunction
endpackage

### src/iaoe_front.sv
// Input stage: accept transactions and queue them for execution
module iaoe_front import iaoe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_stall,
  input  txn_t       in_txn_i,
  output logic       q_valid_o,
  input  logic       q_pop_i,
  output txn_t       q_txn_o
);
  txn_t       mem_q [QDepth];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_stall  = (cnt_q == 2'(QDepth));
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_txn_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q + 1'(push);
    rp_d  = rp_q + 1'(q_pop_i);
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_txn_i;
  end
endmodule

### src/iaoe_back.sv
// Execution stage: architectural state, decode and result buffering
module iaoe_back import iaoe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  txn_t        q_txn_i,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        out_res_o
);
  logic [31:0] rf_q [8];
  logic [31:0] rf_d [8];
  logic [31:0] ip_q, ip_d, fl_q, fl_d, lim_q;
  logic [1:0]  pop_q, pop_d;
  logic [31:0] pa_q, pa_d, sp_q, sp_d;
  logic [2:0]  ps_q, ps_d;
  res_t        r0, r1;
  logic        two;
  res_t        ob_q [2];
  logic        ov_q [2];
  logic        can_take;

  assign can_take  = !ov_q[0] && !ov_q[1] ||
                     (ov_q[0] && !ov_q[1] && !out_stall && !two);
  assign q_pop_o   = q_valid_i && can_take;
  assign out_valid = ov_q[0];
  assign out_res_o = ob_q[0];

  always_comb begin
    txn_t        t;
    logic        lock;
    logic [2:0]  pos;
    logic [7:0]  op, modrm, b0, d8;
    logic [1:0]  md;
    logic [2:0]  rg, rm;
    logic [31:0] addr, dv, sv, sm;
    logic [3:0]  len;
    logic [32:0] ext;
    t = q_txn_i;
    for (int i = 0; i < 8; i++) rf_d[i] = rf_q[i];
    ip_d = ip_q; fl_d = fl_q; pop_d = pop_q; pa_d = pa_q; sp_d = sp_q; ps_d = ps_q;
    r0 = '{kind: KIND_DONE, address: '0, value: '0, status: ST_OK, last: 1'b1};
    r1 = r0;
    two = 1'b0;
    b0 = code_byte(t.lo, t.hi, 3'd0);
    lock = (b0 == LockByte);
    pos = lock ? 3'd1 : 3'd0;
    op = code_byte(t.lo, t.hi, pos + 3'd1);
    modrm = code_byte(t.lo, t.hi, pos + 3'd2);
    md = modrm[7:6]; rg = modrm[5:3]; rm = modrm[2:0];
    d8 = code_byte(t.lo, t.hi, pos + 3'd3);
    addr = '0; len = '0; ext = '0;
    dv = rf_q[rm]; sv = rf_q[rg]; sm = '0;
    unique case (t.cmd)
      CMD_WRITE: begin
        if (!t.idx[3]) rf_d[t.idx[2:0]] = t.data;
        else if (t.idx == 4'd8) ip_d = t.data;
        else if (t.idx == 4'd9) fl_d = t.data;
      end
      CMD_READ: begin
        r0.kind = KIND_REG;
        if (!t.idx[3]) r0.value = rf_q[t.idx[2:0]];
        else if (t.idx == 4'd8) r0.value = ip_q;
        else if (t.idx == 4'd9) r0.value = fl_q;
      end
      CMD_EXEC: begin
        if (pop_q != 2'd0) r0.status = ST_SEQ;
        else if (t.lo == Endbr32Word) ip_d = ip_q + 32'd4;
        else if (code_byte(t.lo, t.hi, pos) != EscByte) r0.status = ST_UNSUP;
        else if (op >= BswapLo && op <= BswapHi) begin
          if (op[2:1] == 2'b10 || lock) r0.status = ST_UNSUP;
          else begin
            sm = rf_q[op[2:0]];
            rf_d[op[2:0]] = {sm[7:0], sm[15:8], sm[23:16], sm[31:24]};
            ip_d = ip_q + 32'(pos) + 32'd2;
          end
        end else if (op != CmpxchgOp && op != XaddOp) r0.status = ST_UNSUP;
        else if (md == 2'd3) begin
          if (op == CmpxchgOp) begin
            if (rf_q[0] == dv) begin fl_d[6] = 1'b1; rf_d[rm] = sv; end
            else begin fl_d[6] = 1'b0; rf_d[0] = dv; end
          end else begin
            fl_d = add_flags(dv, sv, fl_q);
            rf_d[rg] = dv;
            rf_d[rm] = dv + sv;
          end
          ip_d = ip_q + 32'(pos) + 32'd3;
        end else if (rm == 3'd4) r0.status = ST_UNSUP;
        else begin
          if (md == 2'd0 && rm == 3'd5) begin
            addr = code_word(t.lo, t.hi, pos + 3'd3); len = {1'b0, pos} + 4'd7;
          end else if (md == 2'd0) begin
            addr = dv; len = {1'b0, pos} + 4'd3;
          end else if (md == 2'd1) begin
            addr = dv + {{24{d8[7]}}, d8}; len = {1'b0, pos} + 4'd4;
          end else begin
            addr = dv + code_word(t.lo, t.hi, pos + 3'd3); len = {1'b0, pos} + 4'd7;
          end
          ext = {1'b0, addr} + 33'd4;
          if (ext > {1'b0, lim_q}) r0.status = ST_FAULT;
          else begin
            pop_d = (op == CmpxchgOp) ? 2'd1 : 2'd2;
            pa_d = addr; ps_d = rg; sp_d = ip_q + 32'(len);
            r0.kind = KIND_REQ; r0.address = addr;
          end
        end
      end
      CMD_DATA: begin
        if (pop_q == 2'd0) r0.status = ST_SEQ;
        else begin
          sm = rf_q[ps_q];
          if (pop_q == 2'd1) begin
            if (rf_q[0] == t.data) begin
              fl_d[6] = 1'b1; two = 1'b1;
              r0 = '{kind: KIND_WR, address: pa_q, value: sm, status: ST_OK, last: 1'b0};
            end else begin
              fl_d[6] = 1'b0; rf_d[0] = t.data;
            end
          end else begin
            fl_d = add_flags(t.data, sm, fl_q);
            rf_d[ps_q] = t.data;
            two = 1'b1;
            r0 = '{kind: KIND_WR, address: pa_q, value: t.data + sm,
                   status: ST_OK, last: 1'b0};
          end
          ip_d = sp_q; pop_d = 2'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) rf_q[i] <= '0;
      ip_q <= '0; fl_q <= '0; pop_q <= '0; pa_q <= '0; sp_q <= '0; ps_q <= '0;
      lim_q <= LimitReset;
      ov_q[0] <= 1'b0; ov_q[1] <= 1'b0;
    end else begin
      if (cfg_we) lim_q <= cfg_wdata;
      if (q_pop_o) begin
        for (int i = 0; i < 8; i++) rf_q[i] <= rf_d[i];
        ip_q <= ip_d; fl_q <= fl_d; pop_q <= pop_d;
        pa_q <= pa_d; sp_q <= sp_d; ps_q <= ps_d;
      end
      if (q_pop_o) begin
        if (ov_q[0] && !out_stall) begin
          ov_q[0] <= 1'b1; ov_q[1] <= 1'b0;
        end else if (ov_q[0]) begin
          ov_q[1] <= 1'b1;
        end else begin
          ov_q[0] <= 1'b1; ov_q[1] <= two;
        end
      end else if (ov_q[0] && !out_stall) begin
        ov_q[0] <= ov_q[1]; ov_q[1] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (ov_q[0] && !out_stall) ob_q[0] <= r0;
      else if (ov_q[0]) ob_q[1] <= r0;
      else begin ob_q[0] <= r0; ob_q[1] <= r1; end
    end else if (ov_q[0] && !out_stall) ob_q[0] <= ob_q[1];
  end

  `include "i486_atomic_op_executor_defines.svh"
  `ASSERT_IMPL(a_no_hole, clk_i, rst_ni, !ov_q[1] || ov_q[0])
  `ASSERT_IMPL(a_pend_code, clk_i, rst_ni, pop_q != 2'd3)
  `ASSERT_NEXT(a_two_out, clk_i, rst_ni, q_pop_o && two, ov_q[0] && ov_q[1])
endmodule

### src/i486_atomic_op_executor.sv
// Top level of the atomic op executor
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall
//  out     | output    | out_valid / out_stall
//  cfg     | input     | cfg_we / cfg_wdata
// One transaction per cycle while in_stall is low; a memory-data transaction that writes back gives two results.
// The two-entry input queue feeds the execute stage, which owns all architectural state.
// Reset clears registers, IP, flags, pending state and sets the limit to 0xC0000000.
// Output stall backs up into the queue and then into in_stall.
module i486_atomic_op_executor import iaoe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] data_word_i,
  input  logic [31:0] code_low_i,
  input  logic [31:0] code_high_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind_o,
  output logic [31:0] address_o,
  output logic [31:0] value_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  txn_t tin, tq;
  res_t res;
  logic qv, qp;

  assign tin = '{cmd: cmd_e'(command_i), idx: reg_index_i, data: data_word_i,
                 lo: code_low_i, hi: code_high_i};

  iaoe_front u_front (.clk_i, .rst_ni, .in_valid, .in_stall, .in_txn_i(tin),
                      .q_valid_o(qv), .q_pop_i(qp), .q_txn_o(tq));
  iaoe_back u_back (.clk_i, .rst_ni, .cfg_we, .cfg_wdata, .q_valid_i(qv),
                    .q_pop_o(qp), .q_txn_i(tq), .out_valid, .out_stall,
                    .out_res_o(res));

  assign kind_o    = res.kind;
  assign address_o = res.address;
  assign value_o   = res.value;
  assign status_o  = res.status;
  assign last_o    = res.last;
endmodule
